FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module. Each expects signals
// named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define APM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define APM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// Shared widths, controller states and the command bundle of the audio
// peak / RMS level meter.
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int PEAK_W          = 16;
  localparam int RMS_W           = 24;
  localparam int COUNT_OUT_W     = 34;
  localparam int COUNT_WIDTH_DEF = 34;

  // Largest square is 32768^2 = 2^30.
  localparam int MAX_SQ_LOG = 2 * (SAMPLE_W - 1);
  localparam int SQ_W       = 2 * SAMPLE_W;
  // Mean square is scaled by 2^16 before the root.
  localparam int FRAC_SHIFT = 16;
  // Root operand: scaled mean is at most 2^46, padded to an even width.
  localparam int ROOT_IN_W  = 2 * RMS_W;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } apm_state_t;

  typedef struct packed {
    logic acc_en;     // fold the accepted sample into the statistics
    logic div_load;   // start the divide with the updated sum
    logic div_step;   // one restoring divide step
    logic sqrt_step;  // one digit of the square root
    logic out_load;   // load the result register and clear the statistics
  } apm_cmd_t;

endpackage

FILE: sv/apm_if.sv
// ----------------------------------------------------------------------------
// apm_if
// Valid/ready channels of the level meter: sample words in, result words out.
// ----------------------------------------------------------------------------
interface apm_in_if;
  logic                          valid;
  logic                          ready;
  logic [apm_pkg::SAMPLE_W-1:0]  sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface apm_out_if;
  logic                             valid;
  logic                             ready;
  logic [apm_pkg::PEAK_W-1:0]       peak_magnitude;
  logic [apm_pkg::RMS_W-1:0]        rms_level;
  logic [apm_pkg::COUNT_OUT_W-1:0]  sample_count;

  modport source (output valid, output peak_magnitude, output rms_level,
                  output sample_count, input ready);
  modport sink   (input valid, input peak_magnitude, input rms_level,
                  input sample_count, output ready);
endinterface

FILE: sv/apm_datapath.sv
// ----------------------------------------------------------------------------
// apm_datapath
// Statistics accumulators, bit-serial restoring divider, digit-serial square
// root and the result register.
// ----------------------------------------------------------------------------
module apm_datapath #(
  parameter int COUNT_WIDTH = apm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  apm_pkg::apm_cmd_t                cmd,
  input  logic [apm_pkg::SAMPLE_W-1:0]     sample,
  output logic [apm_pkg::PEAK_W-1:0]       peak_magnitude,
  output logic [apm_pkg::RMS_W-1:0]        rms_level,
  output logic [apm_pkg::COUNT_OUT_W-1:0]  sample_count
);

  localparam int SUM_W  = COUNT_WIDTH + apm_pkg::MAX_SQ_LOG;
  localparam int DVD_W  = SUM_W + apm_pkg::FRAC_SHIFT;
  localparam int RW     = apm_pkg::RMS_W;
  localparam int QW     = apm_pkg::ROOT_IN_W;

  // statistics
  logic [apm_pkg::PEAK_W-1:0]   peak_r, peak_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt, sum_upd;
  logic [COUNT_WIDTH-1:0]       cnt_r, cnt_nxt, cnt_upd;
  logic [apm_pkg::SAMPLE_W-1:0] mag;
  logic [apm_pkg::SQ_W-1:0]     sq;
  logic                         cnt_full;

  // divider and root
  logic [DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [COUNT_WIDTH-1:0]   rem_r, rem_nxt;
  logic [COUNT_WIDTH:0]     rem_sh;
  logic [COUNT_WIDTH+1:0]   rem_diff;
  logic                     div_ge;
  logic [QW-1:0]            quot_r, quot_nxt;
  logic [RW:0]              srem_r, srem_nxt;
  logic [RW+2:0]            srem_sh;
  logic [RW+3:0]            srem_diff;
  logic                     sqrt_ge;
  logic [RW-1:0]            root_r, root_nxt;

  // result register
  logic [apm_pkg::PEAK_W-1:0]      peak_o_r;
  logic [RW-1:0]                   rms_o_r;
  logic [apm_pkg::COUNT_OUT_W-1:0] cnt_o_r;

  // -32768 maps to 32768, which still fits 16 unsigned bits
  assign mag      = sample[apm_pkg::SAMPLE_W-1] ? apm_pkg::SAMPLE_W'(~sample + 1'b1) : sample;
  assign sq       = mag * mag;
  assign cnt_full = &cnt_r;
  assign sum_upd  = cnt_full ? sum_r : sum_r + SUM_W'(sq);
  assign cnt_upd  = cnt_full ? cnt_r : cnt_r + 1'b1;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, cnt_r};
  assign div_ge   = !rem_diff[COUNT_WIDTH+1];

  assign srem_sh   = {srem_r, quot_r[QW-1 -: 2]};
  assign srem_diff = {1'b0, srem_sh} - {2'b00, root_r, 2'b01};
  assign sqrt_ge   = !srem_diff[RW+3];

  always_comb begin
    peak_nxt = peak_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    if (cmd.out_load) begin
      peak_nxt = '0;
      sum_nxt  = '0;
      cnt_nxt  = '0;
    end else if (cmd.acc_en) begin
      if (mag > peak_r) begin
        peak_nxt = mag;
      end
      sum_nxt = sum_upd;
      cnt_nxt = cnt_upd;
    end
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    srem_nxt = srem_r;
    root_nxt = root_r;
    priority if (cmd.div_load) begin
      dvd_nxt  = {sum_upd, apm_pkg::FRAC_SHIFT'(0)};
      rem_nxt  = '0;
      quot_nxt = '0;
      srem_nxt = '0;
      root_nxt = '0;
    end else if (cmd.div_step) begin
      dvd_nxt  = dvd_r << 1;
      rem_nxt  = div_ge ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
      // quotient stays below 2^47, so the bits shifted out are zero
      quot_nxt = {quot_r[QW-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      quot_nxt = quot_r << 2;
      srem_nxt = sqrt_ge ? srem_diff[RW:0] : srem_sh[RW:0];
      root_nxt = {root_r[RW-2:0], sqrt_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      peak_r <= peak_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    if (cmd.out_load) begin
      peak_o_r <= peak_r;
      rms_o_r  <= root_r;
      cnt_o_r  <= apm_pkg::COUNT_OUT_W'(cnt_r);
    end
  end

  assign peak_magnitude = peak_o_r;
  assign rms_level      = rms_o_r;
  assign sample_count   = cnt_o_r;

endmodule

FILE: sv/apm_ctrl.sv
// ----------------------------------------------------------------------------
// apm_ctrl
// Sequencer of the level meter: accept samples, run the divide and the root
// after the last word of a capture, then hand the result to the output.
// ----------------------------------------------------------------------------
module apm_ctrl #(
  parameter int COUNT_WIDTH = apm_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output apm_pkg::apm_cmd_t cmd
);

  localparam int DVD_W  = COUNT_WIDTH + apm_pkg::MAX_SQ_LOG + apm_pkg::FRAC_SHIFT;
  localparam int STEP_W = $clog2(DVD_W);

  apm_pkg::apm_state_t state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apm_pkg::ST_ACC;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      apm_pkg::ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last) begin
            cmd.div_load = 1'b1;
            step_nxt     = STEP_W'(DVD_W - 1);
            state_nxt    = apm_pkg::ST_DIV;
          end
        end
      end
      apm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r - 1'b1;
        if (step_r == '0) begin
          step_nxt  = STEP_W'(apm_pkg::RMS_W - 1);
          state_nxt = apm_pkg::ST_SQRT;
        end
      end
      apm_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = apm_pkg::ST_DONE;
        end
      end
      apm_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = apm_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = apm_pkg::ST_ACC;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/audio_peak_rms_meter_top.sv
// ----------------------------------------------------------------------------
// audio_peak_rms_meter_top
// Peak, sample count and RMS level (8 fractional bits) of 16-bit PCM captures.
//
//   channel   dir  word
//   in_ch     in   sample, last_sample
//   out_ch    out  peak_magnitude, rms_level, sample_count
//
// A sample without the last mark is folded in at one word per cycle.
// After the last word, in_ch.ready stays low through ST_DIV (bit-serial divide
// over COUNT_WIDTH + 46 dividend bits), ST_SQRT (24 root digits) and ST_DONE,
// which lasts while an earlier result still waits on out_ch.
// A result waits in the output register without blocking the next capture.
// Reset (synchronous, rst_n low) clears the statistics and the output valid.
// ----------------------------------------------------------------------------
module audio_peak_rms_meter_top #(
  parameter int COUNT_WIDTH = apm_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  apm_in_if.sink    in_ch,
  apm_out_if.source out_ch
);

  apm_pkg::apm_cmd_t cmd;

  apm_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_sample),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  apm_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sample         (in_ch.sample),
    .peak_magnitude (out_ch.peak_magnitude),
    .rms_level      (out_ch.rms_level),
    .sample_count   (out_ch.sample_count)
  );

endmodule

FILE: sv/apm_checker.sv
// ----------------------------------------------------------------------------
// apm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_last_sample,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [apm_pkg::PEAK_W-1:0]       peak_magnitude,
  input logic [apm_pkg::COUNT_OUT_W-1:0]  sample_count
);

  `APM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `APM_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_last_sample, !in_ready, "ready high right after last word")
  `APM_ASSERT_NOW(a_count_nonzero, out_valid, sample_count != '0, "result with zero sample count")
  `APM_ASSERT_NOW(a_peak_range, out_valid, peak_magnitude <= 16'h8000, "peak above full scale")

endmodule

bind audio_peak_rms_meter_top apm_checker u_apm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_last_sample (in_ch.last_sample),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .peak_magnitude (out_ch.peak_magnitude),
  .sample_count   (out_ch.sample_count)
);
